### src/cbfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier forward-difference core.
// No dependencies.
package cbfd_pkg;
   localparam int unsigned COORD_W   = 15;
   localparam int unsigned ACC_W     = 32;
   localparam int unsigned SHIFT_W   = 5;
   localparam int unsigned QUAL_W    = 3;
   localparam int unsigned DEF_MAX_QUALITY = 5;
   localparam int unsigned REQ_DATA_W = 120;
   localparam int unsigned RSP_DATA_W = 96;
   localparam logic [COORD_W-1:0] COORD_MAX = 15'h7fff;
   localparam logic [QUAL_W-1:0]  QUALITY_RESET = 3'd5;

   localparam logic CSR_QUALITY = 1'b0;
   localparam logic CSR_RASTER  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic              emit_last;
      logic [QUAL_W-1:0] quality;
      logic              raster;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;
endpackage

### src/cubic_bezier_forward_difference_core.sv
`timescale 1ns / 1ps
// Top level of the cubic Bezier forward-difference core.
// Depends on cbfd_pkg, cbfd_ctrl and cbfd_dp.
//
//  channel | dir | payload
//  req_    | in  | tdata: 8 curve coordinates, tuser: clear_box
//  rsp_    | out | tdata: vertex and box, tlast: last_point
//  csr_    | in  | index 0 quality, 1 raster_coords
//
// A curve takes one load cycle, then one vertex a cycle while rsp_ is not stalled
// from the two axis step units, end anchor last.
// Reset clears config to quality 5, raster on, and the box to empty.
// A stalled rsp_ holds the vertex and pauses stepping; the next request is
// taken once the end anchor sits in the output register.
module cubic_bezier_forward_difference_core #(
   parameter int unsigned MAX_QUALITY = cbfd_pkg::DEF_MAX_QUALITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // anchor_start_x, control_one_x, control_two_x, anchor_end_x,
   // anchor_start_y, control_one_y, control_two_y, anchor_end_y
   input  logic [cbfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,   // clear_box
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // point_x, point_y, box_min_x, box_min_y, box_max_x, box_max_y
   output logic [cbfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [cbfd_pkg::QUAL_W-1:0]       csr_data
);
   import cbfd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   cbfd_ctrl #(.MAX_QUALITY(MAX_QUALITY)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status)
   );

   cbfd_dp u_dp (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .cmd(cmd), .status(status),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule

### src/cbfd_axis.sv
`timescale 1ns / 1ps
// One axis of forward differencing: setup of differences and adaptive scale stepping.
// Depends on cbfd_pkg.
module cbfd_axis (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          step,
   input  logic [cbfd_pkg::QUAL_W-1:0]   quality,
   input  logic                          raster,
   input  logic [cbfd_pkg::COORD_W-1:0]  p0,
   input  logic [cbfd_pkg::COORD_W-1:0]  p1,
   input  logic [cbfd_pkg::COORD_W-1:0]  p2,
   input  logic [cbfd_pkg::COORD_W-1:0]  p3,
   output logic [cbfd_pkg::COORD_W-1:0]  coord
);
   import cbfd_pkg::*;

   logic signed [ACC_W-1:0]   pos_ff, pos_in, d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic        [SHIFT_W-1:0] fb_ff, fb_in, ds_ff, ds_in;

   // setup
   logic signed [39:0] s1, s2, s3, s1h, s2h, s3h, n1, n2, n3, e0, e1, e2;
   logic        [4:0]  sq;
   logic signed [39:0] spos;

   // step
   logic signed [ACC_W-1:0] v, x0h, dsh, x1, x2;
   logic signed [ACC_W:0]   chk, mx1;
   logic        [SHIFT_W-1:0] q1, qd1, q2, qd2;
   logic        [5:0]        sh1;

   always_comb begin
      e0  = 40'(signed'({1'b0, p0}));
      e1  = 40'(signed'({1'b0, p1}));
      e2  = 40'(signed'({1'b0, p2}));
      s1  = e1 - e0;
      s2  = e2 - e1;
      s3  = 40'(signed'({1'b0, p3})) - e0 - ((s2 <<< 1) + s2);
      s2  = s2 - s1;
      sq  = 5'((quality << 1) + quality);
      if (!raster && quality != '0) begin
         s1h = s1 >>> 1;
         s2h = s2 >>> 1;
         s3h = s3 >>> 1;
         sq  = sq - 5'd1;
      end else begin
         s1h = s1;
         s2h = s2;
         s3h = s3;
      end
      n1   = (((s1h <<< 1) + s1h) <<< (2 * quality)) + (((s2h <<< 1) + s2h) <<< quality) + s3h;
      n3   = (s3h <<< 2) + (s3h <<< 1);
      n2   = (((s2h <<< 2) + (s2h <<< 1)) <<< quality) + n3;
      spos = (e0 <<< sq) + ((sq != '0) ? (40'sd1 <<< (sq - 5'd1)) : 40'sd0);
   end

   always_comb begin
      v     = pos_ff >>> fb_ff;
      coord = (v < 0) ? '0 : ((v > 32767) ? COORD_MAX : v[COORD_W-1:0]);
      x0h   = pos_ff >>> 1;
      sh1   = {1'b0, ds_ff} + 6'd1;
      chk   = 33'(x0h) + 33'(d1_ff >>> sh1);
      if (chk < 0) chk = -chk;
      if (chk >= 33'sh3ffffffe && fb_ff != '0) begin
         x1  = x0h;
         q1  = fb_ff - 5'd1;
         qd1 = ds_ff + 5'd1;
      end else begin
         x1  = pos_ff;
         q1  = fb_ff;
         qd1 = ds_ff;
      end
      dsh = d1_ff >>> qd1;
      x2  = x1 + dsh;
      mx1 = 33'(x2);
      if (mx1 < 0) mx1 = -mx1;
      q2  = q1;
      qd2 = qd1;
      if (qd1 != '0 && mx1 < 33'sh40000000) begin
         x2  = (x2 <<< 1) + 32'sd1;
         q2  = q1 + 5'd1;
         qd2 = qd1 - 5'd1;
      end
   end

   always_comb begin
      pos_in = pos_ff; d1_in = d1_ff; d2_in = d2_ff; d3_in = d3_ff;
      fb_in  = fb_ff;  ds_in = ds_ff;
      if (load) begin
         pos_in = spos[ACC_W-1:0];
         d1_in  = n1[ACC_W-1:0];
         d2_in  = n2[ACC_W-1:0];
         d3_in  = n3[ACC_W-1:0];
         fb_in  = sq;
         ds_in  = '0;
      end else if (step) begin
         pos_in = x2;
         d1_in  = d1_ff + d2_ff;
         d2_in  = d2_ff + d3_ff;
         fb_in  = q2;
         ds_in  = qd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; d1_ff <= '0; d2_ff <= '0; d3_ff <= '0;
         fb_ff  <= '0; ds_ff <= '0;
      end else begin
         pos_ff <= pos_in; d1_ff <= d1_in; d2_ff <= d2_in; d3_ff <= d3_in;
         fb_ff  <= fb_in;  ds_ff <= ds_in;
      end
   end
endmodule

### src/cbfd_ctrl.sv
`timescale 1ns / 1ps
// Controller: configuration registers, vertex counter and run state machine.
// Depends on cbfd_pkg.
module cbfd_ctrl #(
   parameter int unsigned MAX_QUALITY = cbfd_pkg::DEF_MAX_QUALITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [cbfd_pkg::QUAL_W-1:0]   csr_data,
   output cbfd_pkg::dp_cmd_type          cmd,
   input  cbfd_pkg::dp_status_type       status
);
   import cbfd_pkg::*;
   localparam int unsigned CNT_W = MAX_QUALITY + 1;

   ctrl_state_type      state_ff, state_in;
   logic [QUAL_W-1:0]   quality_ff, quality_in, qual_cap;
   logic                raster_ff, raster_in;
   logic [CNT_W-1:0]    count_ff, count_in, n_seg;

   assign csr_ready = 1'b1;
   assign qual_cap  = (quality_ff > QUAL_W'(MAX_QUALITY)) ? QUAL_W'(MAX_QUALITY) : quality_ff;
   assign n_seg     = CNT_W'(1) << qual_cap;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_RUN;
         ST_RUN:  if (!status.out_busy && count_ff == n_seg) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.emit_last = 1'b0;
      cmd.quality   = qual_cap;
      cmd.raster    = raster_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_RUN: begin
            if (!status.out_busy) begin
               if (count_ff == n_seg) cmd.emit_last = 1'b1;
               else                   cmd.step = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      quality_in = quality_ff;
      raster_in  = raster_ff;
      if (csr_valid) begin
         if (csr_index == CSR_QUALITY) quality_in = csr_data;
         else                          raster_in  = csr_data[0];
      end
      count_in = count_ff;
      if (cmd.load)      count_in = '0;
      else if (cmd.step) count_in = count_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         quality_ff <= QUALITY_RESET;
         raster_ff  <= 1'b1;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         quality_ff <= quality_in;
         raster_ff  <= raster_in;
         count_ff   <= count_in;
      end
   end
endmodule

### src/cbfd_dp.sv
`timescale 1ns / 1ps
// Datapath: two axis units, end anchor, bounding box and output register.
// Depends on cbfd_pkg and cbfd_axis.
module cbfd_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cbfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  cbfd_pkg::dp_cmd_type              cmd,
   output cbfd_pkg::dp_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import cbfd_pkg::*;

   logic [COORD_W-1:0] ax, ay, px, py;
   logic [COORD_W-1:0] ex_ff, ey_ff;
   logic [COORD_W-1:0] mnx_ff, mnx_in, mny_ff, mny_in, mxx_ff, mxx_in, mxy_ff, mxy_in;
   logic [COORD_W-1:0] bmnx, bmny, bmxx, bmxy;
   logic [COORD_W-1:0] ox_ff, oy_ff, omnx_ff, omny_ff, omxx_ff, omxy_ff;
   logic               olast_ff, valid_ff, valid_in, emit;

   cbfd_axis u_axis_x (
      .clock(clock), .reset(reset), .load(cmd.load), .step(cmd.step),
      .quality(cmd.quality), .raster(cmd.raster),
      .p0(req_tdata[14:0]), .p1(req_tdata[29:15]),
      .p2(req_tdata[44:30]), .p3(req_tdata[59:45]), .coord(ax)
   );

   cbfd_axis u_axis_y (
      .clock(clock), .reset(reset), .load(cmd.load), .step(cmd.step),
      .quality(cmd.quality), .raster(cmd.raster),
      .p0(req_tdata[74:60]), .p1(req_tdata[89:75]),
      .p2(req_tdata[104:90]), .p3(req_tdata[119:105]), .coord(ay)
   );

   assign emit = cmd.step | cmd.emit_last;
   assign px   = cmd.emit_last ? ex_ff : ax;
   assign py   = cmd.emit_last ? ey_ff : ay;

   always_comb begin
      bmnx = (px < mnx_ff) ? px : mnx_ff;
      bmny = (py < mny_ff) ? py : mny_ff;
      bmxx = (px > mxx_ff) ? px : mxx_ff;
      bmxy = (py > mxy_ff) ? py : mxy_ff;
      mnx_in = mnx_ff; mny_in = mny_ff; mxx_in = mxx_ff; mxy_in = mxy_ff;
      if (cmd.load && req_tuser) begin
         mnx_in = COORD_MAX; mny_in = COORD_MAX; mxx_in = '0; mxy_in = '0;
      end else if (emit) begin
         mnx_in = bmnx; mny_in = bmny; mxx_in = bmxx; mxy_in = bmxy;
      end
      valid_in = valid_ff;
      if (emit)            valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   assign status.out_busy = valid_ff & ~rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = olast_ff;
   // point_x, point_y, box_min_x, box_min_y, box_max_x, box_max_y, zero pad
   assign rsp_tdata  = {6'd0, omxy_ff, omxx_ff, omny_ff, omnx_ff, oy_ff, ox_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mnx_ff <= COORD_MAX; mny_ff <= COORD_MAX; mxx_ff <= '0; mxy_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         mnx_ff <= mnx_in; mny_ff <= mny_in; mxx_ff <= mxx_in; mxy_ff <= mxy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ex_ff <= req_tdata[59:45];
         ey_ff <= req_tdata[119:105];
      end
      if (emit) begin
         ox_ff    <= px;   oy_ff   <= py;
         omnx_ff  <= bmnx; omny_ff <= bmny;
         omxx_ff  <= bmxx; omxy_ff <= bmxy;
         olast_ff <= cmd.emit_last;
      end
   end
endmodule
